/* rtl/websocket_frame_deframer_assert.svh */
// assertion macros for the websocket frame deframer checker
// expects clk and rst_n in the scope where the macros are used
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, off during reset
`define WSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define WSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wsd_pkg.sv */
// shared types and constants of the websocket frame deframer
// no dependencies
package wsd_pkg;

    localparam int CFG_W              = 25;
    localparam int COUNT_BITS_DEFAULT = 25;
    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(1024 * 1024);
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'ha;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        K_MSG        = 3'd0,
        K_PING       = 3'd1,
        K_EMPTY_MSG  = 3'd2,
        K_EMPTY_PING = 3'd3,
        K_CLOSE      = 3'd4,
        K_FRAME_LONG = 3'd5,
        K_MSG_LONG   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // one classified item from the parser to the output side
    typedef struct packed {
        kind_t      kind;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic       is_binary;
        logic       frame_last;
        logic       message_last;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

/* rtl/wsd_if.sv */
// valid/ready channel interfaces for the byte input and the result output
// depends on wsd_pkg
interface wsd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if
    import wsd_pkg::*;
;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       is_binary;
    logic       frame_last;
    logic       message_last;

    modport source (output valid, output kind, output data_byte, output is_binary,
                    output frame_last, output message_last, input ready);
    modport sink   (input valid, input kind, input data_byte, input is_binary,
                    input frame_last, input message_last, output ready);
endinterface

/* rtl/websocket_frame_deframer.sv */
// websocket frame deframer: takes one received byte per cycle while the queue has
// room and gives at most one result per byte. the parser settles each byte in the
// cycle it is accepted and writes its result into a four-entry queue; the result
// is loaded from the queue into the output register once that register is free.
// the input drops ready only when the queue is full, which happens only while the
// output is stalled, so while results are taken the sustained rate is one byte per
// cycle set by the single parser step per byte. frame and message size checks run
// when the length field completes. after close, frame-too-long or message-too-long
// is reported, bytes are still taken but dropped until reset. max_frame_bytes is to
// be written through cfg_wr_en and cfg_wr_data only while the block is idle; the
// block itself does not enforce this. depends on wsd_pkg, wsd_if and the submodules
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    wsd_rx_if.sink           rx,
    wsd_res_if.source        result,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;
    logic  byte_fire;

    // a byte is taken whenever the queue has room, even while a result waits
    assign rx.ready  = !q_full;
    assign byte_fire = rx.valid && rx.ready;

    // header parsing, size checks, length and mask tracking
    wsd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .rx_byte     (rx.rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_wr        (q_wr)
    );

    // decouples parsing from output stalls
    wsd_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    // unmasking and result register
    wsd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_rd  (q_rd),
        .pop   (q_pop),
        .res   (result)
    );

endmodule

/* rtl/wsd_front.sv */
// header parser: classifies each received byte until a stop report and queues at most one item per byte
// depends on wsd_pkg
module wsd_front
    import wsd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_fire,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output q_wr_t            q_wr
);

    localparam int CW1 = COUNT_BITS + 1;

    logic [CFG_W-1:0]      max_frame_reg;
    logic [COUNT_BITS-1:0] lim;

    phase_t                phase_reg,   phase_next;
    logic [2:0]            hcnt_reg,    hcnt_next;
    logic                  fin_reg,     fin_next;
    logic [3:0]            op_reg,      op_next;
    logic                  masked_reg,  masked_next;
    logic [63:0]           flen_reg,    flen_next;
    logic [31:0]           key_reg,     key_next;
    logic [COUNT_BITS-1:0] pidx_reg,    pidx_next;
    logic                  msg_bin_reg, msg_bin_next;
    logic [COUNT_BITS-1:0] mlen_reg,    mlen_next;
    logic                  stop_reg,    stop_next;

    logic                  len_done;
    logic                  hdr_done;
    logic                  data_op;
    logic                  last;
    logic [CW1-1:0]        msg_sum;
    logic [COUNT_BITS-1:0] base;
    logic [7:0]            key_byte;

    // limit in force, capped to what the counters hold
    generate
        if (COUNT_BITS >= CFG_W) begin : g_lim_wide
            assign lim = COUNT_BITS'(max_frame_reg);
        end else begin : g_lim_cap
            assign lim = (max_frame_reg > CFG_W'({COUNT_BITS{1'b1}}))
                       ? {COUNT_BITS{1'b1}} : max_frame_reg[COUNT_BITS-1:0];
        end
    endgenerate

    assign data_op = (op_reg == OP_CONT) || (op_reg == OP_TEXT) || (op_reg == OP_BINARY);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_frame_reg <= MAX_FRAME_RESET;
            phase_reg     <= PH_HDR0;
            hcnt_reg      <= '0;
            fin_reg       <= 1'b0;
            op_reg        <= '0;
            masked_reg    <= 1'b0;
            flen_reg      <= '0;
            key_reg       <= '0;
            pidx_reg      <= '0;
            msg_bin_reg   <= 1'b0;
            mlen_reg      <= '0;
            stop_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_frame_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            hcnt_reg    <= hcnt_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            masked_reg  <= masked_next;
            flen_reg    <= flen_next;
            key_reg     <= key_next;
            pidx_reg    <= pidx_next;
            msg_bin_reg <= msg_bin_next;
            mlen_reg    <= mlen_next;
            stop_reg    <= stop_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        hcnt_next    = hcnt_reg;
        fin_next     = fin_reg;
        op_next      = op_reg;
        masked_next  = masked_reg;
        flen_next    = flen_reg;
        key_next     = key_reg;
        pidx_next    = pidx_reg;
        msg_bin_next = msg_bin_reg;
        mlen_next    = mlen_reg;
        stop_next    = stop_reg;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        q_wr         = '0;
        q_wr.cmd.kind = K_MSG;

        case (pidx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        last = ({1'b0, pidx_reg} + CW1'(1)) >= {1'b0, flen_reg[COUNT_BITS-1:0]};

        if (byte_fire && !stop_reg) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next   = rx_byte[7];
                    op_next    = rx_byte[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = rx_byte[7];
                    key_next    = '0;
                    if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
                        flen_next  = '0;
                        hcnt_next  = (rx_byte[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
                        phase_next = PH_EXTLEN;
                    end else begin
                        flen_next = 64'(rx_byte[6:0]);
                        len_done  = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    flen_next = {flen_reg[55:0], rx_byte};
                    if (hcnt_reg == 3'd0) begin
                        len_done = 1'b1;
                    end else begin
                        hcnt_next = hcnt_reg - 3'd1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (hcnt_reg >= 3'd3) begin
                        hdr_done = 1'b1;
                    end else begin
                        hcnt_next = hcnt_reg + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    if (last) begin
                        phase_next = PH_HDR0;
                    end else begin
                        pidx_next = pidx_reg + COUNT_BITS'(1);
                    end
                    q_wr.cmd.raw_byte   = rx_byte;
                    q_wr.cmd.key_byte   = key_byte;
                    q_wr.cmd.frame_last = last;
                    if (op_reg == OP_PING) begin
                        q_wr.push     = 1'b1;
                        q_wr.cmd.kind = K_PING;
                    end else if (op_reg == OP_CLOSE) begin
                        if (last) begin
                            stop_next           = 1'b1;
                            q_wr.push           = 1'b1;
                            q_wr.cmd            = '0;
                            q_wr.cmd.kind       = K_CLOSE;
                        end
                    end else if (data_op) begin
                        q_wr.push             = 1'b1;
                        q_wr.cmd.kind         = K_MSG;
                        q_wr.cmd.is_binary    = msg_bin_reg;
                        q_wr.cmd.message_last = last && fin_reg;
                        if (last && fin_reg) begin
                            mlen_next = '0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase
        end

        // length known: the frame size check takes priority over the message size check
        base    = (op_reg == OP_CONT) ? mlen_reg : '0;
        msg_sum = {1'b0, base} + {1'b0, flen_next[COUNT_BITS-1:0]};
        if (len_done) begin
            if (flen_next > 64'(lim)) begin
                stop_next     = 1'b1;
                q_wr.push     = 1'b1;
                q_wr.cmd      = '0;
                q_wr.cmd.kind = K_FRAME_LONG;
            end else if (data_op && (msg_sum > {1'b0, lim})) begin
                stop_next     = 1'b1;
                q_wr.push     = 1'b1;
                q_wr.cmd      = '0;
                q_wr.cmd.kind = K_MSG_LONG;
            end else begin
                if (data_op) begin
                    if (op_reg != OP_CONT) begin
                        msg_bin_next = (op_reg == OP_BINARY);
                    end
                    mlen_next = msg_sum[COUNT_BITS-1:0];
                end
                if (masked_next) begin
                    phase_next = PH_MASK;
                    hcnt_next  = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end
        end

        // header complete: start the payload or close out an empty frame
        if (hdr_done) begin
            pidx_next = '0;
            if (flen_next != 64'd0) begin
                phase_next = PH_PAYLOAD;
            end else begin
                phase_next = PH_HDR0;
                q_wr.cmd   = '0;
                if (op_reg == OP_PING) begin
                    q_wr.push           = 1'b1;
                    q_wr.cmd.kind       = K_EMPTY_PING;
                    q_wr.cmd.frame_last = 1'b1;
                end else if (op_reg == OP_CLOSE) begin
                    stop_next     = 1'b1;
                    q_wr.push     = 1'b1;
                    q_wr.cmd.kind = K_CLOSE;
                end else if (data_op && fin_reg) begin
                    mlen_next             = '0;
                    q_wr.push             = 1'b1;
                    q_wr.cmd.kind         = K_EMPTY_MSG;
                    q_wr.cmd.is_binary    = msg_bin_next;
                    q_wr.cmd.frame_last   = 1'b1;
                    q_wr.cmd.message_last = 1'b1;
                end else begin
                    q_wr.cmd.kind = K_MSG;
                end
            end
        end
    end

endmodule

/* rtl/wsd_cmd_queue.sv */
// small fifo of classified items between parser and output side
// depends on wsd_pkg
module wsd_cmd_queue
    import wsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t q_wr,
    input  logic  pop,
    output q_rd_t q_rd,
    output logic  full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_rd.valid = (cnt_reg != '0);
    assign q_rd.cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && q_rd.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_wr.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        case ({q_wr.push, do_pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (q_wr.push) begin
            mem_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

/* rtl/wsd_back.sv */
// output side: unmasks payload bytes and holds the result register
// depends on wsd_pkg and wsd_if
module wsd_back
    import wsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_rd_t     q_rd,
    output logic      pop,
    wsd_res_if.source res
);

    logic       valid_reg;
    kind_t      kind_reg;
    logic [7:0] data_reg;
    logic       bin_reg;
    logic       flast_reg;
    logic       mlast_reg;
    logic [7:0] data_next;

    assign pop = q_rd.valid && (!valid_reg || res.ready);

    // only payload kinds carry a byte
    always_comb begin
        if (q_rd.cmd.kind == K_MSG || q_rd.cmd.kind == K_PING) begin
            data_next = q_rd.cmd.raw_byte ^ q_rd.cmd.key_byte;
        end else begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || res.ready) begin
            valid_reg <= q_rd.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            kind_reg  <= q_rd.cmd.kind;
            data_reg  <= data_next;
            bin_reg   <= q_rd.cmd.is_binary;
            flast_reg <= q_rd.cmd.frame_last;
            mlast_reg <= q_rd.cmd.message_last;
        end
    end

    assign res.valid        = valid_reg;
    assign res.kind         = kind_reg;
    assign res.data_byte    = data_reg;
    assign res.is_binary    = bin_reg;
    assign res.frame_last   = flast_reg;
    assign res.message_last = mlast_reg;

endmodule

/* rtl/wsd_checker.sv */
// port-level checks on the deframer result channel, bound to the top level
// depends on wsd_pkg and websocket_frame_deframer_assert.svh
`include "websocket_frame_deframer_assert.svh"

module wsd_checker
    import wsd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input kind_t      kind,
    input logic [7:0] data_byte,
    input logic       is_binary,
    input logic       frame_last,
    input logic       message_last
);

    logic stop_kind;
    logic byte_kind;
    logic msg_kind;

    assign stop_kind = (kind == K_CLOSE) || (kind == K_FRAME_LONG) || (kind == K_MSG_LONG);
    assign byte_kind = (kind == K_MSG) || (kind == K_PING);
    assign msg_kind  = (kind == K_MSG) || (kind == K_EMPTY_MSG);

    // a stalled result holds
    `WSD_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(kind) && $stable(data_byte), "result changed while stalled")
    // nothing follows a stop report
    `WSD_ASSERT_NXT(a_stop_last, res_valid && res_ready && stop_kind, !res_valid, "item after stop report")
    // only payload kinds carry data
    `WSD_ASSERT_IMP(a_data_zero, res_valid && !byte_kind, data_byte == 8'd0, "data on non-payload kind")
    // end of message is also end of frame, and only message kinds mark it
    `WSD_ASSERT_IMP(a_mlast, res_valid && message_last, frame_last && msg_kind, "bad message end mark")
    // binary tag only on message kinds
    `WSD_ASSERT_IMP(a_bin, res_valid && is_binary, msg_kind, "binary tag on non-message kind")

endmodule

bind websocket_frame_deframer wsd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .kind         (result.kind),
    .data_byte    (result.data_byte),
    .is_binary    (result.is_binary),
    .frame_last   (result.frame_last),
    .message_last (result.message_last)
);
